// File: src/ackermann_wheel_speed_mixer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wheel speed mixer
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ACKERMANN_WHEEL_SPEED_MIXER_TOP_MACROS_SVH
`define ACKERMANN_WHEEL_SPEED_MIXER_TOP_MACROS_SVH

// expression holds at every edge
`define AWSM_CHECK(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("awsm check failed");

// same-cycle implication
`define AWSM_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("awsm implication failed");

// next-cycle implication
`define AWSM_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("awsm next-cycle check failed");

`endif

// File: src/awsm_pkg.sv
// ----------------------------------------------------------------------------
// awsm_pkg
// Widths, reset values and register codes of the wheel speed mixer.
// ----------------------------------------------------------------------------
package awsm_pkg;

	localparam int SPEED_WIDTH_DEF = 16;
	localparam int IN_W            = 16;
	localparam int REAR_W          = 17;
	localparam int FRAC_W          = 12;
	localparam int SQ_W            = 64;
	localparam int ROOT_W          = SQ_W / 2;
	localparam int FRONT_W         = ROOT_W - FRAC_W;
	localparam int LIM_W           = 15;
	localparam int GAIN_W          = 16;
	localparam int DIR_W           = 4;
	localparam int MAP_W           = 8;
	localparam int NUM_WHEELS      = 4;
	localparam int ADDR_W          = 4;
	localparam int DATA_W          = 32;

	localparam logic [LIM_W-1:0]  SPEED_LIMIT_RST  = 15'd1000;
	localparam logic [GAIN_W-1:0] LATERAL_GAIN_RST = 16'd4096;
	localparam logic [DIR_W-1:0]  DIR_MASK_RST     = 4'd0;
	localparam logic [MAP_W-1:0]  CHAN_MAP_RST     = 8'd228;

	localparam logic [1:0] REG_SPEED_LIMIT  = 2'd0;
	localparam logic [1:0] REG_LATERAL_GAIN = 2'd1;
	localparam logic [1:0] REG_DIR_MASK     = 2'd2;
	localparam logic [1:0] REG_CHAN_MAP     = 2'd3;

endpackage

// File: src/ackermann_wheel_speed_mixer_top.sv
// ----------------------------------------------------------------------------
// ackermann_wheel_speed_mixer_top
// Four-wheel mixer: rear = base +/- steer, front = floor(sqrt(rear^2 + lat^2)),
// common scale-down to the speed limit, clamp, per-wheel reverse and routing.
// ----------------------------------------------------------------------------
//  channel | signals                                         | transfer when
//  --------+-------------------------------------------------+----------------------
//  in      | in_valid, in_stall, base_speed, steer           | in_valid & !in_stall
//  out     | out_valid, out_stall, channel_*_speed           | out_valid & !out_stall
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata    | psel & penable & pwrite
//
//  One transfer per cycle unless a valid output stalls: 4 setup stages, 32 root stages
//  (one result bit each), 1 max stage, 15 divide stages, 1 output register.
//  The whole pipe advances together; it holds while the output is stalled.
//  Reset clears all valid bits and loads register defaults.
// ----------------------------------------------------------------------------
`include "ackermann_wheel_speed_mixer_top_macros.svh"

module ackermann_wheel_speed_mixer_top #(
	parameter int SPEED_WIDTH = awsm_pkg::SPEED_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [15:0]            base_speed,
	input  logic signed [15:0]            steer,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SPEED_WIDTH-1:0] channel_one_speed,
	output logic signed [SPEED_WIDTH-1:0] channel_two_speed,
	output logic signed [SPEED_WIDTH-1:0] channel_three_speed,
	output logic signed [SPEED_WIDTH-1:0] channel_four_speed,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [awsm_pkg::ADDR_W-1:0]   paddr,
	input  logic [awsm_pkg::DATA_W-1:0]   pwdata,
	output logic [awsm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	localparam int REAR_W  = awsm_pkg::REAR_W;
	localparam int FRAC_W  = awsm_pkg::FRAC_W;
	localparam int SQ_W    = awsm_pkg::SQ_W;
	localparam int ROOT_W  = awsm_pkg::ROOT_W;
	localparam int FRONT_W = awsm_pkg::FRONT_W;
	localparam int LIM_W   = awsm_pkg::LIM_W;
	localparam int RA_W    = REAR_W + FRAC_W;
	localparam int SQT_W   = REAR_W + 1;
	localparam int PROD_W  = FRONT_W + LIM_W;
	localparam int DVT_W   = FRONT_W + 2;
	localparam logic [32:0] WMAX = (33'd1 << (SPEED_WIDTH - 1)) - 33'd1;

	// ---------------- configuration ----------------
	logic [LIM_W-1:0]              speed_limit_q;
	logic [awsm_pkg::GAIN_W-1:0]   lateral_gain_q;
	logic [awsm_pkg::DIR_W-1:0]    direction_mask_q;
	logic [awsm_pkg::MAP_W-1:0]    channel_map_q;
	logic                          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit_q    <= awsm_pkg::SPEED_LIMIT_RST;
			lateral_gain_q   <= awsm_pkg::LATERAL_GAIN_RST;
			direction_mask_q <= awsm_pkg::DIR_MASK_RST;
			channel_map_q    <= awsm_pkg::CHAN_MAP_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				awsm_pkg::REG_SPEED_LIMIT:  speed_limit_q    <= pwdata[LIM_W-1:0];
				awsm_pkg::REG_LATERAL_GAIN: lateral_gain_q   <= pwdata[15:0];
				awsm_pkg::REG_DIR_MASK:     direction_mask_q <= pwdata[3:0];
				awsm_pkg::REG_CHAN_MAP:     channel_map_q    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			awsm_pkg::REG_SPEED_LIMIT:  prdata = 32'(speed_limit_q);
			awsm_pkg::REG_LATERAL_GAIN: prdata = 32'(lateral_gain_q);
			awsm_pkg::REG_DIR_MASK:     prdata = 32'(direction_mask_q);
			awsm_pkg::REG_CHAN_MAP:     prdata = 32'(channel_map_q);
			default:                    prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	logic out_valid_q;
	logic en;

	assign en        = !out_valid_q || !out_stall;
	assign in_stall  = !en;
	assign out_valid = out_valid_q;

	// ---------------- stage 1: rear wheels ----------------
	logic signed [REAR_W-1:0] rl_d, rr_d;
	logic                     valid_s1;
	logic [REAR_W-1:0]        mag_s1 [2];
	logic                     neg_s1 [2];
	logic [15:0]              st_abs_s1;

	assign rl_d = REAR_W'(base_speed) + REAR_W'(steer);
	assign rr_d = REAR_W'(base_speed) - REAR_W'(steer);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1[0] <= rl_d[REAR_W-1] ? REAR_W'(-rl_d) : REAR_W'(rl_d);
			mag_s1[1] <= rr_d[REAR_W-1] ? REAR_W'(-rr_d) : REAR_W'(rr_d);
			neg_s1[0] <= rl_d[REAR_W-1];
			neg_s1[1] <= rr_d[REAR_W-1];
			st_abs_s1 <= steer[15] ? 16'(-steer) : 16'(steer);
		end
	end

	// ---------------- stage 2: rear squares, lateral term ----------------
	logic                valid_s2;
	logic [2*RA_W-1:0]   ra2_s2 [2];
	logic [31:0]         sa_s2;
	logic [REAR_W-1:0]   mag_s2 [2];
	logic                neg_s2 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				ra2_s2[i] <= (2*RA_W)'({mag_s1[i], {FRAC_W{1'b0}}})
					* (2*RA_W)'({mag_s1[i], {FRAC_W{1'b0}}});
				mag_s2[i] <= mag_s1[i];
				neg_s2[i] <= neg_s1[i];
			end
			sa_s2 <= 32'(st_abs_s1) * 32'(lateral_gain_q);
		end
	end

	// ---------------- stage 3: lateral square ----------------
	logic                valid_s3;
	logic [2*RA_W-1:0]   ra2_s3 [2];
	logic [SQ_W-1:0]     sa2_s3;
	logic [REAR_W-1:0]   mag_s3 [2];
	logic                neg_s3 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ra2_s3 <= ra2_s2;
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			sa2_s3 <= SQ_W'(sa_s2) * SQ_W'(sa_s2);
		end
	end

	// ---------------- stage 4: sum of squares ----------------
	logic              valid_s4;
	logic [SQ_W-1:0]   sum_s4 [2];
	logic [SQT_W-1:0]  tag_s4 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				sum_s4[i] <= SQ_W'(ra2_s3[i]) + sa2_s3;
				tag_s4[i] <= {neg_s3[i], mag_s3[i]};
			end
		end
	end

	// ---------------- square roots (left and right front) ----------------
	logic [1:0]         sq_valid;
	logic [ROOT_W-1:0]  sq_root [2];
	logic [SQT_W-1:0]   sq_tag  [2];

	for (genvar s = 0; s < 2; s++) begin : g_root
		awsm_isqrt #(
			.XW (SQ_W),
			.TW (SQT_W)
		) u_isqrt (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (valid_s4),
			.x         (sum_s4[s]),
			.in_tag    (tag_s4[s]),
			.out_valid (sq_valid[s]),
			.root      (sq_root[s]),
			.out_tag   (sq_tag[s])
		);
	end

	// ---------------- stage 5: largest magnitude, numerators ----------------
	// wheel order: 0 lf, 1 lr, 2 rf, 3 rr
	logic [FRONT_W-1:0] mag_d [4];
	logic [3:0]         neg_d;
	logic [FRONT_W-1:0] max01, max23, max_d;

	always_comb begin
		mag_d[0] = sq_root[0][ROOT_W-1:FRAC_W];
		mag_d[1] = FRONT_W'(sq_tag[0][REAR_W-1:0]);
		mag_d[2] = sq_root[1][ROOT_W-1:FRAC_W];
		mag_d[3] = FRONT_W'(sq_tag[1][REAR_W-1:0]);
		neg_d    = {sq_tag[1][REAR_W], sq_tag[1][REAR_W], sq_tag[0][REAR_W],
			sq_tag[0][REAR_W]};
		max01    = (mag_d[0] > mag_d[1]) ? mag_d[0] : mag_d[1];
		max23    = (mag_d[2] > mag_d[3]) ? mag_d[2] : mag_d[3];
		max_d    = (max01 > max23) ? max01 : max23;
	end

	logic               valid_s5;
	logic [FRONT_W-1:0] mag_s5  [4];
	logic [3:0]         neg_s5;
	logic [FRONT_W-1:0] max_s5;
	logic [PROD_W-1:0]  prod_s5 [4];
	logic               scale_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= sq_valid[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				mag_s5[i]  <= mag_d[i];
				prod_s5[i] <= PROD_W'(mag_d[i]) * PROD_W'(speed_limit_q);
			end
			neg_s5 <= neg_d;
			max_s5 <= max_d;
		end
	end

	assign scale_d = (max_s5 > FRONT_W'(speed_limit_q));

	// ---------------- scale by limit / max ----------------
	logic [3:0]        dv_valid;
	logic [LIM_W-1:0]  dv_q   [4];
	logic [DVT_W-1:0]  dv_tag [4];

	for (genvar w = 0; w < 4; w++) begin : g_div
		awsm_div #(
			.DW (FRONT_W),
			.QW (LIM_W),
			.TW (DVT_W)
		) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (valid_s5),
			.num       (prod_s5[w]),
			.den       (max_s5),
			.in_tag    ({scale_d, neg_s5[w], mag_s5[w]}),
			.out_valid (dv_valid[w]),
			.quot      (dv_q[w]),
			.out_tag   (dv_tag[w])
		);
	end

	// ---------------- output: clamp, reverse, route ----------------
	logic [LIM_W-1:0]       lim;
	logic [FRONT_W-1:0]     sm   [4];
	logic [LIM_W-1:0]       fm   [4];
	logic [32:0]            wv   [4];
	logic [SPEED_WIDTH-1:0] ch_d [4];
	logic [SPEED_WIDTH-1:0] ch_q [4];

	assign lim = (33'(speed_limit_q) > WMAX) ? WMAX[LIM_W-1:0] : speed_limit_q;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			ch_d[c] = '0;
		end
		for (int i = 0; i < 4; i++) begin
			sm[i] = dv_tag[i][FRONT_W+1] ? FRONT_W'(dv_q[i]) : dv_tag[i][FRONT_W-1:0];
			fm[i] = (sm[i] > FRONT_W'(lim)) ? lim : sm[i][LIM_W-1:0];
			wv[i] = (dv_tag[i][FRONT_W] ^ direction_mask_q[i]) ? 33'(-33'(fm[i]))
				: 33'(fm[i]);
			// later wheel wins a shared channel
			ch_d[channel_map_q[2*i +: 2]] = wv[i][SPEED_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= &dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch_q <= ch_d;
		end
	end

	assign channel_one_speed   = ch_q[0];
	assign channel_two_speed   = ch_q[1];
	assign channel_three_speed = ch_q[2];
	assign channel_four_speed  = ch_q[3];

	// ---------------- checks ----------------
	`AWSM_CHECK(a_root_lanes_agree, sq_valid[0] == sq_valid[1])
	`AWSM_CHECK(a_div_lanes_agree, dv_valid == {4{dv_valid[0]}})
	`AWSM_IMPLIES(a_quot_within_limit, dv_valid[0] && dv_tag[0][FRONT_W+1], dv_q[0] <= speed_limit_q)
	`AWSM_IMPLIES(a_max_bounds_all, valid_s5, max_s5 >= mag_s5[0] && max_s5 >= mag_s5[1] && max_s5 >= mag_s5[2] && max_s5 >= mag_s5[3])
	`AWSM_NEXT(a_pipe_holds_on_stall, !en, valid_s1 == $past(valid_s1) && valid_s5 == $past(valid_s5))

endmodule

// File: src/awsm_isqrt.sv
// ----------------------------------------------------------------------------
// awsm_isqrt
// Pipelined integer square root, one result bit per stage, with sideband tag.
// ----------------------------------------------------------------------------
module awsm_isqrt #(
	parameter int XW = awsm_pkg::SQ_W,
	parameter int TW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [XW-1:0]   x,
	input  logic [TW-1:0]   in_tag,
	output logic            out_valid,
	output logic [XW/2-1:0] root,
	output logic [TW-1:0]   out_tag
);
	localparam int RW = XW / 2;

	logic [XW-1:0] x_sk   [0:RW];
	logic [XW-1:0] r_sk   [0:RW];
	logic [TW-1:0] tag_sk [0:RW];
	logic          v_sk   [0:RW];

	always_comb begin
		x_sk[0]   = x;
		r_sk[0]   = '0;
		tag_sk[0] = in_tag;
		v_sk[0]   = in_valid;
	end

	for (genvar k = 0; k < RW; k++) begin : g_step
		localparam logic [XW-1:0] B = XW'(1) << (XW - 2 - 2 * k);
		logic [XW-1:0] rb;
		logic          ge;

		always_comb begin
			rb = r_sk[k] + B;
			ge = (x_sk[k] >= rb);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[k+1] <= 1'b0;
			end else if (en) begin
				v_sk[k+1] <= v_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_sk[k+1]   <= ge ? (x_sk[k] - rb) : x_sk[k];
				r_sk[k+1]   <= ge ? ((r_sk[k] >> 1) + B) : (r_sk[k] >> 1);
				tag_sk[k+1] <= tag_sk[k];
			end
		end
	end

	assign out_valid = v_sk[RW];
	assign root      = r_sk[RW][RW-1:0];
	assign out_tag   = tag_sk[RW];

endmodule

// File: src/awsm_div.sv
// ----------------------------------------------------------------------------
// awsm_div
// Pipelined restoring divider, one quotient bit per stage, with sideband tag.
// The quotient is valid when num < den * 2^QW.
// ----------------------------------------------------------------------------
module awsm_div #(
	parameter int DW = awsm_pkg::FRONT_W,
	parameter int QW = awsm_pkg::LIM_W,
	parameter int TW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [DW+QW-1:0] num,
	input  logic [DW-1:0]    den,
	input  logic [TW-1:0]    in_tag,
	output logic             out_valid,
	output logic [QW-1:0]    quot,
	output logic [TW-1:0]    out_tag
);
	localparam int NW = DW + QW;

	logic [DW-1:0] rem_sk [0:QW];
	logic [QW-1:0] nlo_sk [0:QW];
	logic [QW-1:0] q_sk   [0:QW];
	logic [DW-1:0] den_sk [0:QW];
	logic [TW-1:0] tag_sk [0:QW];
	logic          v_sk   [0:QW];

	always_comb begin
		rem_sk[0] = num[NW-1:QW];
		nlo_sk[0] = num[QW-1:0];
		q_sk[0]   = '0;
		den_sk[0] = den;
		tag_sk[0] = in_tag;
		v_sk[0]   = in_valid;
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0] t;
		logic [DW:0] diff;
		logic        ge;

		always_comb begin
			t    = {rem_sk[k], nlo_sk[k][QW-1]};
			diff = t - {1'b0, den_sk[k]};
			ge   = (t >= {1'b0, den_sk[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[k+1] <= 1'b0;
			end else if (en) begin
				v_sk[k+1] <= v_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
				nlo_sk[k+1] <= {nlo_sk[k][QW-2:0], 1'b0};
				q_sk[k+1]   <= {q_sk[k][QW-2:0], ge};
				den_sk[k+1] <= den_sk[k];
				tag_sk[k+1] <= tag_sk[k];
			end
		end
	end

	assign out_valid = v_sk[QW];
	assign quot      = q_sk[QW];
	assign out_tag   = tag_sk[QW];

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wheel speed mixer testbench
// Drives speed commands through the valid/stall channels with random gaps and
// stalls, rewrites the registers between phases, and checks every channel of
// each transfer against a predictor of the four-wheel mix.
// ----------------------------------------------------------------------------
module tb;

	localparam int SW      = 16;
	localparam int LAT     = 53;
	localparam int WD_LIMIT = 20000;

	typedef struct packed {
		logic signed [SW-1:0] ch1;
		logic signed [SW-1:0] ch2;
		logic signed [SW-1:0] ch3;
		logic signed [SW-1:0] ch4;
	} mix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] base_speed = '0;
	logic signed [15:0] steer = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SW-1:0] channel_one_speed, channel_two_speed;
	logic signed [SW-1:0] channel_three_speed, channel_four_speed;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [awsm_pkg::ADDR_W-1:0] paddr = '0;
	logic [awsm_pkg::DATA_W-1:0] pwdata = '0;
	logic [awsm_pkg::DATA_W-1:0] prdata;
	logic pready;

	// predictor copy of the registers
	logic [awsm_pkg::LIM_W-1:0]  lim_q  = awsm_pkg::SPEED_LIMIT_RST;
	logic [awsm_pkg::GAIN_W-1:0] gain_q = awsm_pkg::LATERAL_GAIN_RST;
	logic [awsm_pkg::DIR_W-1:0]  dir_q  = awsm_pkg::DIR_MASK_RST;
	logic [awsm_pkg::MAP_W-1:0]  map_q  = awsm_pkg::CHAN_MAP_RST;

	mix_t expected_mix[$];
	int errors = 0;
	int idle_cycles = 0;
	int stall_wait = 0;
	bit stall_on = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ackermann_wheel_speed_mixer_top #(.SPEED_WIDTH(SW)) u_dut (.*);

	function automatic longint unsigned root64(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint front_speed(longint rear, longint st);
		longint unsigned ra, sa, m;
		ra = (rear < 0 ? -rear : rear) << 12;
		sa = longint'(st < 0 ? -st : st) * longint'(gain_q);
		m = root64(ra * ra + sa * sa) >> 12;
		return rear >= 0 ? longint'(m) : -longint'(m);
	endfunction

	function automatic mix_t mix_wheels(logic signed [15:0] b, logic signed [15:0] s);
		longint w[4];
		longint ch[4];
		longint unsigned mag[4];
		longint unsigned mx;
		longint lim, v;
		mix_t r;
		mx = 0;
		ch = '{0, 0, 0, 0};
		w[1] = longint'(b) + longint'(s);
		w[3] = longint'(b) - longint'(s);
		w[0] = front_speed(w[1], s);
		w[2] = front_speed(w[3], s);
		for (int i = 0; i < 4; i++) begin
			mag[i] = w[i] < 0 ? -w[i] : w[i];
			if (mag[i] > mx) mx = mag[i];
		end
		if (mx > lim_q) begin
			for (int i = 0; i < 4; i++) begin
				v = longint'((mag[i] * lim_q) / mx);
				w[i] = w[i] < 0 ? -v : v;
			end
		end
		lim = lim_q;
		if (lim > (1 << (SW - 1)) - 1) lim = (1 << (SW - 1)) - 1;
		for (int i = 0; i < 4; i++) begin
			v = w[i];
			if (v > lim) v = lim;
			if (v < -lim) v = -lim;
			if (dir_q[i]) v = -v;
			ch[map_q[2*i +: 2]] = v;
		end
		r.ch1 = ch[0][SW-1:0];
		r.ch2 = ch[1][SW-1:0];
		r.ch3 = ch[2][SW-1:0];
		r.ch4 = ch[3][SW-1:0];
		return r;
	endfunction

	// valid stays high after a transfer; the next caller drops or reuses it
	task automatic drive_item(logic signed [15:0] b, logic signed [15:0] s);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		base_speed <= b;
		steer <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_mix.push_back(mix_wheels(b, s));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_mix.size() != 0) @(posedge clk);
		repeat (LAT + 5) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [awsm_pkg::DATA_W-1:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= awsm_pkg::ADDR_W'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			awsm_pkg::REG_SPEED_LIMIT:  lim_q  = val[awsm_pkg::LIM_W-1:0];
			awsm_pkg::REG_LATERAL_GAIN: gain_q = val[awsm_pkg::GAIN_W-1:0];
			awsm_pkg::REG_DIR_MASK:     dir_q  = val[awsm_pkg::DIR_W-1:0];
			default:                    map_q  = val[awsm_pkg::MAP_W-1:0];
		endcase
	endtask

	task automatic set_regs(int lim, int gain, int dir, int map);
		drain();
		write_reg(awsm_pkg::REG_SPEED_LIMIT, lim);
		write_reg(awsm_pkg::REG_LATERAL_GAIN, gain);
		write_reg(awsm_pkg::REG_DIR_MASK, dir);
		write_reg(awsm_pkg::REG_CHAN_MAP, map);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic signed [15:0] rand_speed();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 64)) - 16'sd32;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_extremes();
		logic signed [15:0] v[6] = '{16'sh7FFF, 16'sh8000, 0, 1, -1, 16'sd1000};
		foreach (v[i]) foreach (v[j]) if (j < 3) drive_item(v[i], v[j]);
		drive_item(16'sd300, 16'sd400);
		drive_item(-16'sd300, 16'sd400);
		drive_item(16'sd5, 16'sh5555);
		drive_item(-16'sd6, 16'shAAAA);
	endtask

	task automatic test_zero_limit();
		set_regs(0, 4096, 0, 228);
		drive_item(16'sd100, 16'sd7);
		drive_item(0, 0);
		drive_item(16'sh8000, 16'sh7FFF);
	endtask

	// first lf and rf share channel 0, lr on 1, rr on 2, channel 3 unassigned; then all four share channel 0
	task automatic test_shared_channels();
		set_regs(32767, 65535, 4'b0101, 8'b10_00_01_00);
		for (int i = 0; i < 8; i++) drive_item(rand_speed(), rand_speed());
		set_regs(32767, 0, 4'b1010, 8'b00_00_00_00);
		for (int i = 0; i < 8; i++) drive_item(rand_speed(), rand_speed());
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0)
				set_regs((i % 200 == 0) ? $urandom_range(0, 32767) : 32767,
					$urandom_range(0, 65535), $urandom_range(0, 15),
					$urandom_range(0, 255));
			if (i % 60 == 30) stall_on = ~stall_on;
			if (i == 250) drain();
			drive_item(rand_speed(), rand_speed());
		end
	endtask

	// receiver draws a stall length for each result after its transfer
	always @(posedge clk) begin
		int n;
		if (stall_wait > 0) begin
			stall_wait <= stall_wait - 1;
			out_stall <= (stall_wait > 1);
		end else if (out_valid && !out_stall) begin
			n = stall_on ? int'($urandom_range(0, 7)) : 0;
			stall_wait <= n;
			out_stall <= (n != 0);
		end
	end

	// result check
	always @(posedge clk) begin
		mix_t exp_v, got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{channel_one_speed, channel_two_speed, channel_three_speed,
				channel_four_speed};
			if (expected_mix.size() == 0) begin
				$display("%0t unexpected transfer: actual %p", $time, got);
				errors++;
			end else begin
				exp_v = expected_mix.pop_front();
				if (exp_v.ch1 !== got.ch1 || exp_v.ch2 !== got.ch2 ||
				    exp_v.ch3 !== got.ch3 || exp_v.ch4 !== got.ch4) begin
					$display("%0t mismatch: expected %p actual %p", $time, exp_v, got);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("[ackermann_wheel_speed_mixer_top] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_zero_limit();
		test_shared_channels();
		test_random(440);
		set_regs(32767, 65535, 15, 27);
		for (int i = 0; i < 20; i++) drive_item(rand_speed(), rand_speed());
		drain();
		if (errors == 0)
			$display("[ackermann_wheel_speed_mixer_top] OK");
		else
			$display("[ackermann_wheel_speed_mixer_top] ERROR");
		$finish;
	end

endmodule
